/* src/ccl_pkg.sv */
// Shared types and constants for the chain coordinate liftover block.
// Used by ccl_table and chain_coordinate_liftover; depends on nothing.
`default_nettype none
package ccl_pkg;
	localparam int TableDepth   = 4096;
	localparam int CoordBits    = 32;
	localparam int AddrBits     = $clog2(TableDepth);
	localparam int CntBits      = $clog2(TableDepth + 1);
	localparam int ChromBits    = 5;
	localparam logic [ChromBits-1:0] PrimaryLimit = 5'd24;

	typedef enum logic [1:0] {
		MODE_HEADER = 2'd0,
		MODE_BLOCK  = 2'd1,
		MODE_QUERY  = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_STORED   = 3'd0,
		ST_SKIPPED  = 3'd1,
		ST_FULL     = 3'd2,
		ST_LIFTED   = 3'd3,
		ST_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_OFFS,
		S_MAP,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                 rev;
		logic [ChromBits-1:0] dchrom;
		logic [ChromBits-1:0] schrom;
	} tags_t;

	typedef struct packed {
		tags_t                tags;
		logic [CoordBits-1:0] dsize;
		logic [CoordBits-1:0] dstart;
		logic [CoordBits-1:0] send;
		logic [CoordBits-1:0] sstart;
	} entry_t;

	typedef struct packed {
		logic                wr_en;
		logic [AddrBits-1:0] wr_addr;
		logic                rd_en;
		logic [AddrBits-1:0] rd_addr;
	} tbl_ctl_t;
endpackage
`default_nettype wire

/* src/ccl_table.sv */
// Block table memory: one write port, one registered read port.
// Depends on ccl_pkg for the entry layout and depth.
`default_nettype none
module ccl_table (
	input  wire             clk,
	input  wire ccl_pkg::tbl_ctl_t ctl,
	input  wire ccl_pkg::entry_t   wr_data,
	output ccl_pkg::entry_t rd_data
);
	ccl_pkg::entry_t mem [ccl_pkg::TableDepth];
	ccl_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
		if (ctl.rd_en) begin
			rd_q <= mem[ctl.rd_addr];
		end
	end

	assign rd_data = rd_q;
endmodule
`default_nettype wire

/* src/chain_coordinate_liftover.sv */
// Headers/blocks: result the cycle after the transfer; next item then unless stalled.
// Lift query: linear scan of the stored blocks through one memory read port,
// then the offset, map (on a hit) and done states, one item at a time.
// The scan compare unit is shared over all entries, one entry per cycle.
// arst_n clears the chain state, block count and handshake; table is unset.
// Depends on ccl_pkg and ccl_table.
`default_nettype none
module chain_coordinate_liftover (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         item_valid,
	output logic        item_stall,
	input  wire  [1:0]  mode,
	input  wire  [4:0]  source_chrom,
	input  wire  [4:0]  dest_chrom,
	input  wire         source_plus,
	input  wire         dest_minus,
	input  wire  [31:0] start_source,
	input  wire  [31:0] start_dest,
	input  wire  [31:0] dest_size,
	input  wire  [31:0] block_size,
	input  wire  [31:0] gap_source,
	input  wire  [31:0] gap_dest,
	input  wire  [31:0] query_pos,
	output logic        result_valid,
	input  wire         result_stall,
	output logic [2:0]  status,
	output logic [4:0]  lifted_chrom,
	output logic [31:0] lifted_pos,
	output logic        lifted_reverse,
	output logic [12:0] block_count
);
	localparam int CB = ccl_pkg::CoordBits;

	ccl_pkg::state_t state_q, state_d;
	logic                       keep_q;
	logic [CB-1:0]              run_src_q, run_dst_q, run_dsize_q;
	ccl_pkg::tags_t             run_tags_q;
	logic [ccl_pkg::CntBits-1:0] cnt_q, idx_q;
	logic [CB-1:0]              z_q, off_q, qz_q;
	logic [ccl_pkg::ChromBits-1:0] src_q;
	logic                       found_q, rd_vld_s1;
	ccl_pkg::entry_t            best_q, rd_data, wr_data;
	ccl_pkg::tbl_ctl_t          tctl;
	logic                       out_vld_q;
	ccl_pkg::status_t           out_status_q;
	logic [4:0]                 out_chrom_q;
	logic [31:0]                out_pos_q;
	logic                       out_rev_q;

	logic accept, out_free, issue, hit, miss;
	logic [CB-1:0] blk_end, adv_src, adv_dst, mapped;
	ccl_pkg::mode_t md;

	assign md       = ccl_pkg::mode_t'(mode);
	assign out_free = !out_vld_q || !result_stall;
	assign item_stall = (state_q != ccl_pkg::S_IDLE) || !out_free;
	assign accept   = item_valid && !item_stall;
	assign issue    = (state_q == ccl_pkg::S_SCAN) && (idx_q < cnt_q);
	assign hit      = rd_vld_s1 && (rd_data.tags.schrom == src_q)
		&& (rd_data.sstart <= z_q) && (!found_q || rd_data.sstart >= best_q.sstart);
	assign miss     = !found_q || (z_q >= best_q.send);

	assign blk_end  = run_src_q + block_size[CB-1:0];
	assign adv_src  = blk_end + gap_source[CB-1:0];
	assign adv_dst  = run_dst_q + block_size[CB-1:0] + gap_dest[CB-1:0];
	assign mapped   = best_q.tags.rev ? (best_q.dsize - qz_q) : (qz_q + {{(CB-1){1'b0}}, 1'b1});

	always_comb begin
		wr_data.tags   = run_tags_q;
		wr_data.dsize  = run_dsize_q;
		wr_data.dstart = run_dst_q;
		wr_data.send   = blk_end;
		wr_data.sstart = run_src_q;
	end

	always_comb begin
		tctl.wr_en   = accept && (md == ccl_pkg::MODE_BLOCK) && keep_q
			&& (cnt_q < ccl_pkg::CntBits'(ccl_pkg::TableDepth));
		tctl.wr_addr = cnt_q[ccl_pkg::AddrBits-1:0];
		tctl.rd_en   = issue;
		tctl.rd_addr = idx_q[ccl_pkg::AddrBits-1:0];
	end

	ccl_table u_table (
		.clk     (clk),
		.ctl     (tctl),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ccl_pkg::S_IDLE: begin
				if (accept && md == ccl_pkg::MODE_QUERY && query_pos != '0) begin
					state_d = ccl_pkg::S_SCAN;
				end
			end
			ccl_pkg::S_SCAN: begin
				if (!issue && !rd_vld_s1) begin
					state_d = ccl_pkg::S_OFFS;
				end
			end
			ccl_pkg::S_OFFS: state_d = miss ? ccl_pkg::S_DONE : ccl_pkg::S_MAP;
			ccl_pkg::S_MAP:  state_d = ccl_pkg::S_DONE;
			ccl_pkg::S_DONE: begin
				if (out_free) begin
					state_d = ccl_pkg::S_IDLE;
				end
			end
			default: state_d = ccl_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ccl_pkg::S_IDLE;
			keep_q    <= 1'b0;
			run_src_q <= '0;
			run_dst_q <= '0;
			run_dsize_q <= '0;
			run_tags_q <= '0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= issue;
			// a query at a nonzero position holds the result register empty until the done state
			if (accept) begin
				out_vld_q <= !(md == ccl_pkg::MODE_QUERY && query_pos != '0);
			end else if (state_q == ccl_pkg::S_DONE && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !result_stall) begin
				out_vld_q <= 1'b0;
			end
			if (accept) begin
				unique case (md)
					ccl_pkg::MODE_HEADER: begin
						keep_q <= (source_chrom <= ccl_pkg::PrimaryLimit)
							&& (dest_chrom <= ccl_pkg::PrimaryLimit) && source_plus;
						if ((source_chrom <= ccl_pkg::PrimaryLimit)
							&& (dest_chrom <= ccl_pkg::PrimaryLimit) && source_plus) begin
							run_src_q   <= start_source[CB-1:0];
							run_dst_q   <= start_dest[CB-1:0];
							run_dsize_q <= dest_size[CB-1:0];
							run_tags_q  <= {dest_minus, dest_chrom, source_chrom};
						end
					end
					ccl_pkg::MODE_BLOCK: begin
						if (keep_q) begin
							run_src_q <= adv_src;
							run_dst_q <= adv_dst;
							if (tctl.wr_en) begin
								cnt_q <= cnt_q + ccl_pkg::CntBits'(1);
							end
						end
					end
					ccl_pkg::MODE_QUERY: ;
					ccl_pkg::MODE_UNUSED: ;
					default: ;
				endcase
			end
		end
	end

	// payload and scan datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			out_chrom_q <= '0;
			out_pos_q   <= '0;
			out_rev_q   <= 1'b0;
			unique case (md)
				ccl_pkg::MODE_HEADER: begin
					out_status_q <= ((source_chrom <= ccl_pkg::PrimaryLimit)
						&& (dest_chrom <= ccl_pkg::PrimaryLimit) && source_plus)
						? ccl_pkg::ST_STORED : ccl_pkg::ST_SKIPPED;
				end
				ccl_pkg::MODE_BLOCK: begin
					out_status_q <= !keep_q ? ccl_pkg::ST_SKIPPED
						: (tctl.wr_en ? ccl_pkg::ST_STORED : ccl_pkg::ST_FULL);
				end
				ccl_pkg::MODE_QUERY: out_status_q <= ccl_pkg::ST_NOTFOUND;
				ccl_pkg::MODE_UNUSED: out_status_q <= ccl_pkg::ST_SKIPPED;
				default: out_status_q <= ccl_pkg::ST_SKIPPED;
			endcase
			z_q     <= query_pos[CB-1:0] - {{(CB-1){1'b0}}, 1'b1};
			src_q   <= source_chrom;
			idx_q   <= '0;
			found_q <= 1'b0;
		end
		if (issue) begin
			idx_q <= idx_q + ccl_pkg::CntBits'(1);
		end
		if (hit) begin
			best_q  <= rd_data;
			found_q <= 1'b1;
		end
		if (state_q == ccl_pkg::S_OFFS) begin
			off_q <= z_q - best_q.sstart;
		end
		if (state_q == ccl_pkg::S_MAP) begin
			qz_q <= best_q.dstart + off_q;
		end
		if (state_q == ccl_pkg::S_DONE && out_free) begin
			if (miss) begin
				out_status_q <= ccl_pkg::ST_NOTFOUND;
				out_chrom_q  <= '0;
				out_pos_q    <= '0;
				out_rev_q    <= 1'b0;
			end else begin
				out_status_q <= ccl_pkg::ST_LIFTED;
				out_chrom_q  <= best_q.tags.dchrom;
				out_pos_q    <= mapped;
				out_rev_q    <= best_q.tags.rev;
			end
		end
	end

	assign result_valid   = out_vld_q;
	assign status         = out_status_q;
	assign lifted_chrom   = out_chrom_q;
	assign lifted_pos     = out_pos_q;
	assign lifted_reverse = out_rev_q;
	assign block_count    = cnt_q;
endmodule
`default_nettype wire

/* src/ccl_checker.sv */
// Port-level checks for chain_coordinate_liftover, attached with bind.
// Depends on the top level's ports only.
`default_nettype none
module ccl_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        item_valid,
	input wire        item_stall,
	input wire [1:0]  mode,
	input wire [31:0] query_pos,
	input wire        result_valid,
	input wire        result_stall,
	input wire [2:0]  status,
	input wire [4:0]  lifted_chrom,
	input wire [31:0] lifted_pos,
	input wire        lifted_reverse
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(status)
			&& $stable(lifted_pos))
		else $error("stalled result changed");

	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> status <= 3'd4)
		else $error("status code out of range");

	a_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status != 3'd3 |-> lifted_pos == '0 && lifted_chrom == '0
			&& !lifted_reverse)
		else $error("lift fields set on a non-lifted result");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && mode == 2'd2 && query_pos != '0
			|=> item_stall && !result_valid)
		else $error("query did not occupy the block");
endmodule

bind chain_coordinate_liftover ccl_checker u_ccl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.item_valid     (item_valid),
	.item_stall     (item_stall),
	.mode           (mode),
	.query_pos      (query_pos),
	.result_valid   (result_valid),
	.result_stall   (result_stall),
	.status         (status),
	.lifted_chrom   (lifted_chrom),
	.lifted_pos     (lifted_pos),
	.lifted_reverse (lifted_reverse)
);
`default_nettype wire

/* tb/tb_chain_coordinate_liftover.sv */
// Self-checking testbench for chain_coordinate_liftover: directed and random stimulus.
// A scoreboard class predicts every result; depends on ccl_pkg and the RTL top level only.
`timescale 1ns / 100ps
`default_nettype none
module tb_chain_coordinate_liftover;

	// Slowest run: each query scans every stored block while the result side holds off at random.
	localparam int unsigned CycleLimit = 4000000;
	localparam int unsigned RandomItems = 1400;

	typedef struct {
		ccl_pkg::mode_t md;
		bit [4:0]    src;
		bit [4:0]    dst;
		bit          splus;
		bit          dminus;
		bit [31:0]   sstart;
		bit [31:0]   dstart;
		bit [31:0]   dsize;
		bit [31:0]   bsize;
		bit [31:0]   sgap;
		bit [31:0]   dgap;
		bit [31:0]   qpos;
	} lift_item_t;

	typedef struct {
		ccl_pkg::status_t st;
		bit [4:0]    chrom;
		bit [31:0]   pos;
		bit          rev;
		bit [12:0]   count;
	} lift_answer_t;

	class liftover_scoreboard;
		bit            keep;
		bit [31:0]     run_src;
		bit [31:0]     run_dst;
		bit [31:0]     run_dsize;
		bit [10:0]     run_tags;
		bit [31:0]     blk_start[ccl_pkg::TableDepth];
		bit [31:0]     blk_end[ccl_pkg::TableDepth];
		bit [31:0]     blk_dstart[ccl_pkg::TableDepth];
		bit [31:0]     blk_dsize[ccl_pkg::TableDepth];
		bit [10:0]     blk_tags[ccl_pkg::TableDepth];
		int unsigned   stored;
		int unsigned   errors;
		lift_answer_t  awaited[$];

		function new();
			keep = 0;
			run_src = 0;
			run_dst = 0;
			run_dsize = 0;
			run_tags = 0;
			stored = 0;
			errors = 0;
		endfunction

		task report(string msg);
			$display("MISMATCH at %0t: %s", $time, msg);
			errors++;
		endtask

		// Advance the liftover state by one item and queue the answer it must give.
		function void note_input(lift_item_t it);
			lift_answer_t a;
			bit [31:0]    z;
			bit [31:0]    qz;
			int           best;
			a.st = ccl_pkg::ST_SKIPPED;
			a.chrom = '0;
			a.pos = '0;
			a.rev = 1'b0;
			best = -1;
			case (it.md)
				ccl_pkg::MODE_HEADER: begin
					keep = it.src <= ccl_pkg::PrimaryLimit && it.dst <= ccl_pkg::PrimaryLimit
						&& it.splus;
					if (keep) begin
						run_src = it.sstart;
						run_dst = it.dstart;
						run_dsize = it.dsize;
						run_tags = {it.dminus, it.dst, it.src};
						a.st = ccl_pkg::ST_STORED;
					end
				end
				ccl_pkg::MODE_BLOCK: begin
					if (keep) begin
						if (stored >= ccl_pkg::TableDepth) begin
							a.st = ccl_pkg::ST_FULL;
						end else begin
							blk_start[stored] = run_src;
							blk_end[stored] = run_src + it.bsize;
							blk_dstart[stored] = run_dst;
							blk_dsize[stored] = run_dsize;
							blk_tags[stored] = run_tags;
							stored++;
							a.st = ccl_pkg::ST_STORED;
						end
						run_src = run_src + it.bsize + it.sgap;
						run_dst = run_dst + it.bsize + it.dgap;
					end
				end
				ccl_pkg::MODE_QUERY: begin
					a.st = ccl_pkg::ST_NOTFOUND;
					if (it.qpos != 0) begin
						z = it.qpos - 32'd1;
						// ties go to the latest stored block
						for (int i = 0; i < stored; i++)
							if (blk_tags[i][4:0] == it.src && blk_start[i] <= z)
								if (best < 0 || blk_start[i] >= blk_start[best])
									best = i;
						if (best >= 0 && z < blk_end[best]) begin
							qz = blk_dstart[best] + (z - blk_start[best]);
							if (blk_tags[best][10])
								qz = blk_dsize[best] - 32'd1 - qz;
							a.st = ccl_pkg::ST_LIFTED;
							a.chrom = blk_tags[best][9:5];
							a.pos = qz + 32'd1;
							a.rev = blk_tags[best][10];
						end
					end
				end
				default: ;
			endcase
			a.count = stored[12:0];
			awaited.push_back(a);
		endfunction

		task check_result(lift_answer_t got);
			lift_answer_t exp_a;
			if (awaited.size() == 0) begin
				report("result with nothing outstanding");
				return;
			end
			exp_a = awaited.pop_front();
			if (got.st !== exp_a.st)
				report($sformatf("status %0d, predicted %0d", got.st, exp_a.st));
			if (got.chrom !== exp_a.chrom)
				report($sformatf("lifted_chrom %0d, predicted %0d", got.chrom, exp_a.chrom));
			if (got.pos !== exp_a.pos)
				report($sformatf("lifted_pos %h, predicted %h", got.pos, exp_a.pos));
			if (got.rev !== exp_a.rev)
				report($sformatf("lifted_reverse %b, predicted %b", got.rev, exp_a.rev));
			if (got.count !== exp_a.count)
				report($sformatf("block_count %0d, predicted %0d", got.count, exp_a.count));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	logic [1:0]  mode;
	logic [4:0]  source_chrom;
	logic [4:0]  dest_chrom;
	logic        source_plus;
	logic        dest_minus;
	logic [31:0] start_source;
	logic [31:0] start_dest;
	logic [31:0] dest_size;
	logic [31:0] block_size;
	logic [31:0] gap_source;
	logic [31:0] gap_dest;
	logic [31:0] query_pos;
	logic        result_valid;
	logic        result_stall;
	logic [2:0]  status;
	logic [4:0]  lifted_chrom;
	logic [31:0] lifted_pos;
	logic        lifted_reverse;
	logic [12:0] block_count;

	liftover_scoreboard sb = new();
	int unsigned cycles = 0;
	int unsigned results_seen;
	bit          send_burst;
	bit          recv_burst;
	bit          hold_done;

	chain_coordinate_liftover DUT (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic lift_item_t blank_item(ccl_pkg::mode_t md);
		lift_item_t it;
		it.md = md;
		it.src = '0;
		it.dst = '0;
		it.splus = 1'b0;
		it.dminus = 1'b0;
		it.sstart = '0;
		it.dstart = '0;
		it.dsize = '0;
		it.bsize = '0;
		it.sgap = '0;
		it.dgap = '0;
		it.qpos = '0;
		return it;
	endfunction

	function automatic lift_item_t header(bit [4:0] s, bit [4:0] d, bit plus, bit minus,
			bit [31:0] ss, bit [31:0] ds, bit [31:0] dsz);
		lift_item_t it = blank_item(ccl_pkg::MODE_HEADER);
		it.src = s;
		it.dst = d;
		it.splus = plus;
		it.dminus = minus;
		it.sstart = ss;
		it.dstart = ds;
		it.dsize = dsz;
		return it;
	endfunction

	function automatic lift_item_t block(bit [31:0] sz, bit [31:0] gs, bit [31:0] gd);
		lift_item_t it = blank_item(ccl_pkg::MODE_BLOCK);
		it.bsize = sz;
		it.sgap = gs;
		it.dgap = gd;
		return it;
	endfunction

	function automatic lift_item_t query(bit [4:0] s, bit [31:0] p);
		lift_item_t it = blank_item(ccl_pkg::MODE_QUERY);
		it.src = s;
		it.qpos = p;
		return it;
	endfunction

	// Mostly well-formed chains on a few chromosomes with small coordinates, so that
	// queries land in stored blocks; the rest is full-range noise.
	function automatic lift_item_t random_item();
		lift_item_t it;
		int unsigned pick = $urandom_range(0, 99);
		int unsigned idx;
		it = blank_item(ccl_pkg::MODE_HEADER);
		it.src = 5'($urandom);
		it.dst = 5'($urandom);
		it.splus = 1'($urandom);
		it.dminus = 1'($urandom);
		it.sstart = $urandom;
		it.dstart = $urandom;
		it.dsize = $urandom;
		it.bsize = $urandom;
		it.sgap = $urandom;
		it.dgap = $urandom;
		it.qpos = $urandom;
		if (pick < 8) begin
			if ($urandom_range(0, 3) != 0) begin
				it.src = 5'($urandom_range(0, 3));
				it.dst = 5'($urandom_range(0, 24));
				it.splus = 1'b1;
				it.sstart = $urandom_range(0, 20000);
				it.dstart = $urandom_range(0, 1000000);
				it.dsize = $urandom_range(1000000, 3000000);
			end
		end else if (pick < 58) begin
			it.md = ccl_pkg::MODE_BLOCK;
			if ($urandom_range(0, 19) != 0) begin
				it.bsize = $urandom_range(0, 300);
				it.sgap = $urandom_range(0, 100);
				it.dgap = $urandom_range(0, 100);
			end
		end else if (pick < 97) begin
			it.md = ccl_pkg::MODE_QUERY;
			if (sb.stored > 0 && $urandom_range(0, 9) < 7) begin
				idx = $urandom_range(0, sb.stored - 1);
				it.src = sb.blk_tags[idx][4:0];
				it.qpos = sb.blk_start[idx] + $urandom_range(0, 310);
			end else if ($urandom_range(0, 1)) begin
				it.src = 5'($urandom_range(0, 3));
				it.qpos = $urandom_range(0, 25000);
			end
		end else begin
			it.md = ccl_pkg::MODE_UNUSED;
		end
		return it;
	endfunction

	task automatic send_item(lift_item_t it);
		int unsigned gap = send_burst ? 0 : $urandom_range(0, 11);
		repeat (gap) begin
			@(negedge clk);
			item_valid = 1'b0;
		end
		@(negedge clk);
		mode = it.md;
		source_chrom = it.src;
		dest_chrom = it.dst;
		source_plus = it.splus;
		dest_minus = it.dminus;
		start_source = it.sstart;
		start_dest = it.dstart;
		dest_size = it.dsize;
		block_size = it.bsize;
		gap_source = it.sgap;
		gap_dest = it.dgap;
		query_pos = it.qpos;
		item_valid = 1'b1;
		do @(posedge clk); while (item_stall);
		sb.note_input(it);
	endtask

	// Result side: random hold-offs, bursts without any, and one long hold-off.
	initial begin
		int unsigned wait_cycles;
		lift_answer_t got;
		result_stall = 1'b0;
		recv_burst = 0;
		hold_done = 0;
		results_seen = 0;
		forever begin
			wait_cycles = recv_burst ? 0 : $urandom_range(0, 11);
			if (!hold_done && results_seen == 150) begin
				wait_cycles = 400;
				hold_done = 1;
			end
			repeat (wait_cycles) begin
				@(negedge clk);
				result_stall = 1'b1;
			end
			@(negedge clk);
			result_stall = 1'b0;
			do @(posedge clk); while (!result_valid);
			got.st = ccl_pkg::status_t'(status);
			got.chrom = lifted_chrom;
			got.pos = lifted_pos;
			got.rev = lifted_reverse;
			got.count = block_count;
			sb.check_result(got);
			results_seen++;
			if (results_seen % 97 == 0)
				recv_burst = $urandom_range(0, 2) == 0;
		end
	end

	initial begin
		lift_item_t directed[$];
		int unsigned drain;
		send_burst = 0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		mode = ccl_pkg::MODE_HEADER;
		source_chrom = '0;
		dest_chrom = '0;
		source_plus = 1'b0;
		dest_minus = 1'b0;
		start_source = '0;
		start_dest = '0;
		dest_size = '0;
		block_size = '0;
		gap_source = '0;
		gap_dest = '0;
		query_pos = '0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// block before any header, unused mode, query at zero and on an empty table
		directed.push_back(block(32'd10, 32'd0, 32'd0));
		directed.push_back(blank_item(ccl_pkg::MODE_UNUSED));
		directed.push_back(query(5'd0, 32'd0));
		directed.push_back(query(5'd0, 32'hFFFF_FFFF));
		// rejected headers; the block after the first is skipped
		directed.push_back(header(5'd25, 5'd0, 1'b1, 1'b0, 32'd0, 32'd0, 32'd100));
		directed.push_back(block(32'd10, 32'd0, 32'd0));
		directed.push_back(header(5'd0, 5'd31, 1'b1, 1'b0, 32'd0, 32'd0, 32'd100));
		directed.push_back(header(5'd0, 5'd0, 1'b0, 1'b0, 32'd0, 32'd0, 32'd100));
		// reverse-strand chain on the highest primary codes
		directed.push_back(header(5'd24, 5'd24, 1'b1, 1'b1, 32'd100, 32'd50, 32'd1000));
		directed.push_back(block(32'd10, 32'd5, 32'd7));
		directed.push_back(block(32'd0, 32'd0, 32'd0));
		directed.push_back(query(5'd24, 32'd101));
		directed.push_back(query(5'd24, 32'd110));
		directed.push_back(query(5'd24, 32'd111));
		// block whose end wraps past the top of the coordinate range
		directed.push_back(header(5'd0, 5'd22, 1'b1, 1'b0, 32'hFFFF_FFF0, 32'hFFFF_FFFF,
			32'hFFFF_FFFF));
		directed.push_back(block(32'h20, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
		directed.push_back(query(5'd0, 32'hFFFF_FFFF));
		// two blocks at the same start: the later one wins
		directed.push_back(header(5'd1, 5'd2, 1'b1, 1'b0, 32'd500, 32'd0, 32'd5000));
		directed.push_back(block(32'd20, 32'd0, 32'd0));
		directed.push_back(header(5'd1, 5'd3, 1'b1, 1'b0, 32'd500, 32'd1000, 32'd5000));
		directed.push_back(block(32'd5, 32'd0, 32'd0));
		directed.push_back(query(5'd1, 32'd503));
		directed.push_back(query(5'd1, 32'd510));
		directed.push_back(block(32'hFFFF_FFFF, 32'd0, 32'd0));
		foreach (directed[i])
			send_item(directed[i]);

		for (int n = 0; n < RandomItems; n++) begin
			if (n % 89 == 0)
				send_burst = $urandom_range(0, 2) == 0;
			send_item(random_item());
		end
		send_burst = 0;

		// rejected header between kept chains, then queries across them
		send_item(header(5'd5, 5'd6, 1'b1, 1'b1, 32'd1000, 32'd0, 32'h0100_0000));
		send_item(block(32'd4, 32'd1, 32'd1));
		send_item(header(5'd26, 5'd6, 1'b1, 1'b0, 32'd0, 32'd0, 32'd0));
		send_item(block(32'd4, 32'd1, 32'd1));
		send_item(header(5'd5, 5'd7, 1'b1, 1'b0, 32'h4000_0000, 32'd0, 32'd0));
		send_item(block(32'd8, 32'd0, 32'd0));
		send_item(query(5'd5, 32'd1001));
		send_item(query(5'd5, 32'd3000));
		send_item(query(5'd5, 32'h4000_0001));
		send_item(query(5'd6, 32'd1001));
		@(negedge clk);
		item_valid = 1'b0;

		drain = 0;
		while (sb.awaited.size() != 0 && drain < 200000) begin
			@(posedge clk);
			drain++;
		end
		repeat (ccl_pkg::TableDepth + 20) @(posedge clk);
		if (sb.awaited.size() != 0)
			sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
`default_nettype wire
